// ===== rtl/pvg_pkg.sv =====
// ----------------------------------------------------------------------------
// pvg_pkg
// Shared types, constants and the CORDIC arctangent table for the regular
// polygon vertex generator.
// ----------------------------------------------------------------------------
`default_nettype none
package pvg_pkg;

  localparam int MaxVertices = 64;
  localparam int AngleBits   = 16;
  localparam int CordicSteps = 16;
  localparam int CntW        = 7;
  localparam int IdxW        = 6;
  localparam int CoordW      = 17;
  localparam int DivW        = AngleBits + 1;
  localparam int VecW        = 33;

  localparam logic [CntW-1:0]      MaxCount = CntW'(MaxVertices);
  localparam logic [AngleBits-1:0] Quarter  = AngleBits'(1 << (AngleBits - 2));
  localparam logic [VecW-1:0]      GainQ30  = VecW'(652032874);

  typedef struct packed {
    logic [AngleBits-1:0] start_angle;
    logic [AngleBits-1:0] step;
    logic [CntW-1:0]      count;
    logic signed [15:0]   cx;
    logic signed [15:0]   cy;
    logic [14:0]          r;
  } cmd_t;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_t;

  typedef enum logic [2:0] {B_IDLE, B_START, B_ROT, B_Q15, B_PX, B_PY, B_OUT} back_state_t;

  function automatic logic [VecW-1:0] atan_turn(input logic [3:0] i);
    logic [VecW-1:0] v;
    begin
      v = '0;
      unique case (i)
        4'd0:  v = VecW'(536870912);
        4'd1:  v = VecW'(316933406);
        4'd2:  v = VecW'(167458907);
        4'd3:  v = VecW'(85004756);
        4'd4:  v = VecW'(42667331);
        4'd5:  v = VecW'(21354465);
        4'd6:  v = VecW'(10679838);
        4'd7:  v = VecW'(5340245);
        4'd8:  v = VecW'(2670163);
        4'd9:  v = VecW'(1335086);
        4'd10: v = VecW'(667544);
        4'd11: v = VecW'(333772);
        4'd12: v = VecW'(166886);
        4'd13: v = VecW'(83443);
        4'd14: v = VecW'(41722);
        4'd15: v = VecW'(20861);
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pvg_front.sv =====
// ----------------------------------------------------------------------------
// pvg_front
// Accepts requests, clamps the count, and derives the angle step and start
// angle with a shared restoring divider before queuing a command.
// ----------------------------------------------------------------------------
`default_nettype none
module pvg_front import pvg_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [CntW-1:0]     vertex_count,
  input  wire logic signed [15:0]  center_x,
  input  wire logic signed [15:0]  center_y,
  input  wire logic [14:0]         radius,
  output logic                     push,
  output cmd_t                     push_cmd,
  input  wire logic                full
);

  front_state_t state, state_next;
  logic [CntW-1:0]      n;
  logic signed [15:0]   cx, cy;
  logic [14:0]          r;
  logic [DivW-1:0]      dividend, quo;
  logic [CntW-1:0]      rem;
  logic [4:0]           cnt;
  logic                 pass;
  logic [AngleBits-1:0] step, start;

  logic [CntW:0]        rem_sh;
  logic                 ge;
  logic [DivW-1:0]      quo_next;
  logic [CntW-1:0]      n_sat;

  assign n_sat    = (vertex_count > MaxCount) ? MaxCount : vertex_count;
  assign rem_sh   = {rem, dividend[DivW-1]};
  assign ge       = rem_sh >= {1'b0, n};
  assign quo_next = {quo[DivW-2:0], ge};
  assign in_stall = (state != F_IDLE);
  assign push     = (state == F_PUSH) && !full;
  assign push_cmd = '{start_angle: start, step: step, count: n, cx: cx, cy: cy, r: r};

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (in_valid && vertex_count != '0) state_next = F_DIV;
      F_DIV: begin
        if (cnt == 5'(DivW - 1) && (pass || n[0])) state_next = F_PUSH;
      end
      F_PUSH: if (!full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      F_IDLE: begin
        n        <= n_sat;
        cx       <= center_x;
        cy       <= center_y;
        r        <= radius;
        dividend <= DivW'(1 << AngleBits) + DivW'(n_sat >> 1);
        rem      <= '0;
        quo      <= '0;
        cnt      <= '0;
        pass     <= 1'b0;
      end
      F_DIV: begin
        rem      <= ge ? CntW'(rem_sh - {1'b0, n}) : rem_sh[CntW-1:0];
        dividend <= {dividend[DivW-2:0], 1'b0};
        quo      <= quo_next;
        cnt      <= cnt + 5'd1;
        if (cnt == 5'(DivW - 1)) begin
          cnt <= '0;
          rem <= '0;
          quo <= '0;
          if (!pass) begin
            step     <= quo_next[AngleBits-1:0];
            start    <= Quarter;
            pass     <= 1'b1;
            dividend <= DivW'(1 << (AngleBits - 1)) + DivW'(n >> 1);
          end else begin
            start <= Quarter + quo_next[AngleBits-1:0];
          end
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/pvg_queue.sv =====
// ----------------------------------------------------------------------------
// pvg_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none
module pvg_queue import pvg_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output cmd_t      head
);

  cmd_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

endmodule
`default_nettype wire

// ===== rtl/pvg_back.sv =====
// ----------------------------------------------------------------------------
// pvg_back
// Walks the vertices of one command: iterative CORDIC rotation, scaling by
// the radius, centering, and a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none
module pvg_back import pvg_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  head_valid,
  input  wire cmd_t                  head,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [CoordW-1:0]   vertex_x,
  output logic signed [CoordW-1:0]   vertex_y,
  output logic [IdxW-1:0]            vertex_index,
  output logic                       is_last
);

  back_state_t state, state_next;
  logic [AngleBits-1:0] angle, step;
  logic [CntW-1:0]      left;
  logic [IdxW-1:0]      idx;
  logic signed [15:0]   cx, cy, c, s;
  logic [14:0]          r;
  logic signed [VecW-1:0] x, y, z;
  logic [3:0]           it;
  logic                 flip;
  logic signed [31:0]   px;
  logic signed [32:0]   py;

  logic                 fold;
  logic [AngleBits-1:0] a_fold;
  logic signed [VecW-1:0] dx, dy, at;
  logic signed [VecW:0] xf, yf, xr, yr;
  logic signed [16:0]   neg_s;
  logic signed [33:0]   sum_x, sum_y, tx, ty;
  logic                 out_free, fire;

  function automatic logic signed [15:0] sat_q15(input logic signed [VecW:0] v);
    logic signed [VecW:0] q;
    begin
      q = v >>> 15;
      if (q > (VecW+1)'(32767))       return 16'sh7FFF;
      else if (q < -(VecW+1)'(32768)) return 16'sh8000;
      else                            return q[15:0];
    end
  endfunction

  assign fold   = angle[AngleBits-1] ^ angle[AngleBits-2];
  assign a_fold = angle ^ {fold, {(AngleBits-1){1'b0}}};
  assign dx     = y >>> it;
  assign dy     = x >>> it;
  assign at     = $signed(atan_turn(it));
  assign xf     = flip ? -(VecW+1)'(x) : (VecW+1)'(x);
  assign yf     = flip ? -(VecW+1)'(y) : (VecW+1)'(y);
  assign xr     = xf + (VecW+1)'(1 << 14);
  assign yr     = yf + (VecW+1)'(1 << 14);
  assign neg_s  = -17'(s);
  assign sum_x  = 34'(px) + 34'($signed({cx, 15'b0}));
  assign sum_y  = 34'(py) + 34'($signed({cy, 15'b0}));
  assign tx     = sum_x[33] ? (sum_x + 34'sd32767) >>> 15 : sum_x >>> 15;
  assign ty     = sum_y[33] ? (sum_y + 34'sd32767) >>> 15 : sum_y >>> 15;
  assign out_free = !out_valid || !out_stall;
  assign fire   = (state == B_OUT) && out_free;
  assign pop    = fire && (left == CntW'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (head_valid) state_next = B_START;
      B_START: state_next = B_ROT;
      B_ROT:   if (it == 4'(CordicSteps - 1)) state_next = B_Q15;
      B_Q15:   state_next = B_PX;
      B_PX:    state_next = B_PY;
      B_PY:    state_next = B_OUT;
      B_OUT:   if (out_free) state_next = (left == CntW'(1)) ? B_IDLE : B_START;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      state <= state_next;
      if (fire) begin
        out_valid <= 1'b1;
        idx       <= (left == CntW'(1)) ? '0 : idx + IdxW'(1);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        angle <= head.start_angle;
        step  <= head.step;
        left  <= head.count;
        cx    <= head.cx;
        cy    <= head.cy;
        r     <= head.r;
      end
      B_START: begin
        x    <= GainQ30;
        y    <= '0;
        z    <= VecW'($signed({a_fold, {(32-AngleBits){1'b0}}}));
        flip <= fold;
        it   <= '0;
      end
      B_ROT: begin
        if (!z[VecW-1]) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end
        it <= it + 4'd1;
      end
      B_Q15: begin
        c <= sat_q15(xr);
        s <= sat_q15(yr);
      end
      B_PX: px <= 32'(c) * 32'($signed({1'b0, r}));
      B_PY: py <= 33'(neg_s) * 33'($signed({1'b0, r}));
      B_OUT: begin
        if (out_free) begin
          vertex_x     <= tx[CoordW-1:0];
          vertex_y     <= ty[CoordW-1:0];
          vertex_index <= idx;
          is_last      <= (left == CntW'(1));
          left         <= left - CntW'(1);
          angle        <= angle + step;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/regular_polygon_vertex_generator.sv =====
// ----------------------------------------------------------------------------
// regular_polygon_vertex_generator
// An accepted request is divided once for the angle step and, for even counts,
// once more for the start angle, then queued. Each vertex takes setup, 16 CORDIC
// iterations, rounding, two multiplies and output on the shared rotator, which
// works on one vertex at a time and holds while the output stalls; a two-entry
// queue lets the next request be prepared meanwhile.
// Reset clears the control state and the queue; words in flight are dropped.
// ----------------------------------------------------------------------------
`default_nettype none
module regular_polygon_vertex_generator import pvg_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [CntW-1:0]       vertex_count,
  input  wire logic signed [15:0]    center_x,
  input  wire logic signed [15:0]    center_y,
  input  wire logic [14:0]           radius,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [CoordW-1:0]   vertex_x,
  output logic signed [CoordW-1:0]   vertex_y,
  output logic [IdxW-1:0]            vertex_index,
  output logic                       is_last
);

  logic push, full, pop, head_valid;
  cmd_t push_cmd, head;

  pvg_front u_front (
    .clk, .rst, .in_valid, .in_stall, .vertex_count, .center_x, .center_y,
    .radius, .push, .push_cmd, .full
  );

  pvg_queue u_queue (
    .clk, .rst, .push, .push_cmd, .full, .pop, .head_valid, .head
  );

  pvg_back u_back (
    .clk, .rst, .head_valid, .head, .pop, .out_valid, .out_stall,
    .vertex_x, .vertex_y, .vertex_index, .is_last
  );

endmodule
`default_nettype wire
